// File: design/pqfb_pkg.sv
`default_nettype none

package pqfb_pkg;

    localparam int NUM_QUEUES  = 1024;
    localparam int NUM_ENTRIES = 1024;

    localparam int QID_W  = $clog2(NUM_QUEUES);
    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
    localparam int PID_W  = 22;
    localparam int STAT_W = 2;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;
    localparam int M_PAD_W  = M_DATA_W - PID_W - CNT_W;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_FETCH = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] head;
        logic [IDX_W-1:0] tail;
    } qent_t;

    typedef struct packed {
        logic             alloc;
        logic             release_en;
        logic [IDX_W-1:0] rel_idx;
    } free_ctl_t;

    typedef struct packed {
        logic             full;
        logic [IDX_W-1:0] alloc_idx;
        logic [IDX_W-1:0] fhead;
    } free_stat_t;

endpackage

`default_nettype wire

// File: design/per_queue_fifo_bank_unit.sv
// Channel   Dir  Handshake           tdata / tuser
// s         in   s_tvalid, s_tready  tdata: queue_id, pid_in; tuser: mode
// m         out  m_tvalid, m_tready  tdata: pid_out, queue_len; tuser: status
//
// Enqueue and dequeue on an empty queue complete in S_LOOK; dequeue with data completes in S_FETCH
// (queue state read, then entry read, both synchronous memories).
// After reset a clearing pass zeroes the queue state memory, with s_tready low.
// One item is in work at a time; s_tready is high only in idle.
// A held result (m_tready low) stalls completion of the next item, not its acceptance.
`default_nettype none

module per_queue_fifo_bank_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [pqfb_pkg::S_DATA_W-1:0]   s_tdata,  // queue_id[9:0], pid_in[31:10]
    input  wire logic                            s_tuser,  // mode[0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [pqfb_pkg::M_DATA_W-1:0]   m_tdata,  // pid_out[21:0], queue_len[32:22]
    output logic      [pqfb_pkg::STAT_W-1:0]     m_tuser   // status[1:0]
);

    localparam int QW = $bits(pqfb_pkg::qent_t);

    pqfb_pkg::state_t            state_reg, state_next;
    logic [pqfb_pkg::QID_W-1:0]  clr_reg, clr_next;
    logic                        mode_reg;
    logic [pqfb_pkg::QID_W-1:0]  qid_reg;
    logic [pqfb_pkg::PID_W-1:0]  pid_reg;
    logic                        ovalid_reg, ovalid_next;
    logic [pqfb_pkg::PID_W-1:0]  opid_reg, opid_next;
    pqfb_pkg::status_t           ostat_reg, ostat_next;
    logic [pqfb_pkg::CNT_W-1:0]  ocnt_reg, ocnt_next;

    logic                        accept;
    logic                        out_free;
    logic                        load;

    logic                        q_we;
    logic [pqfb_pkg::QID_W-1:0]  q_waddr;
    pqfb_pkg::qent_t             q_wdata;
    logic [QW-1:0]               q_rdata_raw;
    pqfb_pkg::qent_t             q_rd;

    logic                        n_we;
    logic [pqfb_pkg::IDX_W-1:0]  n_waddr;
    logic [pqfb_pkg::IDX_W-1:0]  n_wdata;
    logic                        n_re;
    logic [pqfb_pkg::IDX_W-1:0]  n_raddr;
    logic [pqfb_pkg::IDX_W-1:0]  n_rdata;

    logic                        p_we;
    logic                        p_re;
    logic [pqfb_pkg::PID_W-1:0]  p_rdata;

    pqfb_pkg::free_ctl_t         fctl;
    pqfb_pkg::free_stat_t        fst;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == pqfb_pkg::S_IDLE);
    assign out_free = !ovalid_reg || m_tready;
    assign q_rd     = pqfb_pkg::qent_t'(q_rdata_raw);

    pqfb_ram #(.WIDTH(QW), .DEPTH(pqfb_pkg::NUM_QUEUES)) u_qmem (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (accept),
        .raddr (s_tdata[pqfb_pkg::QID_W-1:0]),
        .rdata (q_rdata_raw)
    );

    pqfb_ram #(.WIDTH(pqfb_pkg::IDX_W), .DEPTH(pqfb_pkg::NUM_ENTRIES)) u_next (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .re    (n_re),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    pqfb_ram #(.WIDTH(pqfb_pkg::PID_W), .DEPTH(pqfb_pkg::NUM_ENTRIES)) u_pid (
        .clk   (clk),
        .we    (p_we),
        .waddr (fst.alloc_idx),
        .wdata (pid_reg),
        .re    (p_re),
        .raddr (q_rd.head),
        .rdata (p_rdata)
    );

    pqfb_free u_free (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .link  (n_rdata),
        .stat  (fst)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        ovalid_next = ovalid_reg && !m_tready;
        opid_next   = opid_reg;
        ostat_next  = ostat_reg;
        ocnt_next   = ocnt_reg;
        load        = 1'b0;
        q_we        = 1'b0;
        q_waddr     = qid_reg;
        q_wdata     = q_rd;
        n_we        = 1'b0;
        n_waddr     = q_rd.tail;
        n_wdata     = fst.alloc_idx;
        n_re        = accept;
        n_raddr     = fst.fhead;
        p_we        = 1'b0;
        p_re        = 1'b0;
        fctl        = '0;
        fctl.rel_idx = q_rd.head;

        unique case (state_reg)
            pqfb_pkg::S_CLEAR:
            begin
                q_we    = 1'b1;
                q_waddr = clr_reg;
                q_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == pqfb_pkg::QID_W'(pqfb_pkg::NUM_QUEUES - 1))
                begin
                    state_next = pqfb_pkg::S_IDLE;
                end
            end
            pqfb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = pqfb_pkg::S_LOOK;
                end
            end
            pqfb_pkg::S_LOOK:
            begin
                if (mode_reg == pqfb_pkg::MODE_DEQ)
                begin
                    if (q_rd.cnt != '0)
                    begin
                        n_re       = 1'b1;
                        n_raddr    = q_rd.head;
                        p_re       = 1'b1;
                        state_next = pqfb_pkg::S_FETCH;
                    end
                    else if (out_free)
                    begin
                        load       = 1'b1;
                        opid_next  = '0;
                        ostat_next = pqfb_pkg::ST_EMPTY;
                        ocnt_next  = '0;
                        state_next = pqfb_pkg::S_IDLE;
                    end
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    opid_next  = '0;
                    state_next = pqfb_pkg::S_IDLE;
                    if (fst.full)
                    begin
                        ostat_next = pqfb_pkg::ST_FULL;
                        ocnt_next  = q_rd.cnt;
                    end
                    else
                    begin
                        ostat_next   = pqfb_pkg::ST_OK;
                        ocnt_next    = q_rd.cnt + 1'b1;
                        fctl.alloc   = 1'b1;
                        p_we         = 1'b1;
                        n_we         = (q_rd.cnt != '0);
                        q_we         = 1'b1;
                        q_wdata.cnt  = q_rd.cnt + 1'b1;
                        q_wdata.head = (q_rd.cnt == '0) ? fst.alloc_idx : q_rd.head;
                        q_wdata.tail = fst.alloc_idx;
                    end
                end
            end
            pqfb_pkg::S_FETCH:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    opid_next       = p_rdata;
                    ostat_next      = pqfb_pkg::ST_OK;
                    ocnt_next       = q_rd.cnt - 1'b1;
                    q_we            = 1'b1;
                    q_wdata.cnt     = q_rd.cnt - 1'b1;
                    q_wdata.head    = n_rdata;
                    n_we            = 1'b1;
                    n_waddr         = q_rd.head;
                    n_wdata         = fst.fhead;
                    fctl.release_en = 1'b1;
                    state_next      = pqfb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pqfb_pkg::S_IDLE;
            end
        endcase

        if (load)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pqfb_pkg::S_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser;
            qid_reg  <= s_tdata[pqfb_pkg::QID_W-1:0];
            pid_reg  <= s_tdata[pqfb_pkg::QID_W +: pqfb_pkg::PID_W];
        end
        opid_reg  <= opid_next;
        ostat_reg <= ostat_next;
        ocnt_reg  <= ocnt_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{pqfb_pkg::M_PAD_W{1'b0}}, ocnt_reg, opid_reg};
    assign m_tuser  = ostat_reg;

    a_alloc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        fctl.alloc |-> !fst.full)
        else $error("allocation from an exhausted entry store");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        load && (ostat_next == pqfb_pkg::ST_FULL) |-> fst.full && (mode_reg == pqfb_pkg::MODE_ENQ))
        else $error("full status without an exhausted store");

    a_fetch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pqfb_pkg::S_FETCH) |-> (q_rd.cnt != '0))
        else $error("dequeue fetch on an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_we |-> (q_wdata.cnt <= pqfb_pkg::CNT_W'(pqfb_pkg::NUM_ENTRIES)))
        else $error("queue count beyond store size");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == pqfb_pkg::S_LOOK
                                  || state_reg == pqfb_pkg::S_FETCH))
        else $error("result raised outside completion");

endmodule

`default_nettype wire

// File: design/pqfb_ram.sv
`default_nettype none

module pqfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/pqfb_free.sv
`default_nettype none

module pqfb_free (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pqfb_pkg::free_ctl_t           ctl,
    input  wire logic [pqfb_pkg::IDX_W-1:0]    link,
    output pqfb_pkg::free_stat_t               stat
);

    logic [pqfb_pkg::CNT_W-1:0] fresh_reg, fresh_next;
    logic [pqfb_pkg::CNT_W-1:0] rec_reg, rec_next;
    logic [pqfb_pkg::IDX_W-1:0] fhead_reg, fhead_next;
    logic                       rec_avail;

    assign rec_avail      = (rec_reg != '0);
    assign stat.full      = !rec_avail
                            && (fresh_reg == pqfb_pkg::CNT_W'(pqfb_pkg::NUM_ENTRIES));
    assign stat.alloc_idx = rec_avail ? fhead_reg : fresh_reg[pqfb_pkg::IDX_W-1:0];
    assign stat.fhead     = fhead_reg;

    always_comb
    begin
        fresh_next = fresh_reg;
        rec_next   = rec_reg;
        fhead_next = fhead_reg;
        if (ctl.alloc)
        begin
            if (rec_avail)
            begin
                fhead_next = link;
                rec_next   = rec_reg - 1'b1;
            end
            else
            begin
                fresh_next = fresh_reg + 1'b1;
            end
        end
        else if (ctl.release_en)
        begin
            fhead_next = ctl.rel_idx;
            rec_next   = rec_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= '0;
            rec_reg   <= '0;
            fhead_reg <= '0;
        end
        else
        begin
            fresh_reg <= fresh_next;
            rec_reg   <= rec_next;
            fhead_reg <= fhead_next;
        end
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 8000;
    localparam int IDLE_PCT    = 26;

    typedef struct {
        logic [pqfb_pkg::PID_W-1:0] pid;
        pqfb_pkg::status_t          status;
        logic [pqfb_pkg::CNT_W-1:0] waiting;
    } dequeue_result_t;

    class queue_bank_shadow;
        logic [pqfb_pkg::IDX_W-1:0] q_head [pqfb_pkg::NUM_QUEUES];
        logic [pqfb_pkg::IDX_W-1:0] q_tail [pqfb_pkg::NUM_QUEUES];
        logic [pqfb_pkg::CNT_W-1:0] q_len [pqfb_pkg::NUM_QUEUES];
        logic [pqfb_pkg::IDX_W-1:0] link [pqfb_pkg::NUM_ENTRIES];
        logic [pqfb_pkg::PID_W-1:0] slot_pid [pqfb_pkg::NUM_ENTRIES];
        logic [pqfb_pkg::IDX_W-1:0] free_top;
        logic [pqfb_pkg::CNT_W-1:0] free_avail;
        dequeue_result_t            due_results[$];
        int                         n_seen;
        int                         errors;

        function new();
            for (int i = 0; i < pqfb_pkg::NUM_QUEUES; i++)
            begin
                q_head[i] = '0;
                q_tail[i] = '0;
                q_len[i]  = '0;
            end
            for (int i = 0; i < pqfb_pkg::NUM_ENTRIES; i++)
            begin
                link[i]     = pqfb_pkg::IDX_W'(i + 1);
                slot_pid[i] = '0;
            end
            free_top   = '0;
            free_avail = pqfb_pkg::CNT_W'(pqfb_pkg::NUM_ENTRIES);
            n_seen     = 0;
            errors     = 0;
        endfunction

        function void note_op(logic mode, logic [pqfb_pkg::QID_W-1:0] qid,
                              logic [pqfb_pkg::PID_W-1:0] pid);
            dequeue_result_t r;
            logic [pqfb_pkg::IDX_W-1:0] e;
            r.pid    = '0;
            r.status = pqfb_pkg::ST_OK;
            if (mode == pqfb_pkg::MODE_ENQ)
            begin
                if (free_avail == 0)
                    r.status = pqfb_pkg::ST_FULL;
                else
                begin
                    e           = free_top;
                    free_top    = link[e];
                    free_avail  = free_avail - 1'b1;
                    slot_pid[e] = pid;
                    if (q_len[qid] == 0)
                        q_head[qid] = e;
                    else
                        link[q_tail[qid]] = e;
                    q_tail[qid] = e;
                    q_len[qid]  = q_len[qid] + 1'b1;
                end
            end
            else
            begin
                if (q_len[qid] == 0)
                    r.status = pqfb_pkg::ST_EMPTY;
                else
                begin
                    e           = q_head[qid];
                    r.pid       = slot_pid[e];
                    q_head[qid] = link[e];
                    q_len[qid]  = q_len[qid] - 1'b1;
                    link[e]     = free_top;
                    free_top    = e;
                    free_avail  = free_avail + 1'b1;
                end
            end
            r.waiting = q_len[qid];
            due_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [pqfb_pkg::PID_W-1:0] pid, logic [pqfb_pkg::STAT_W-1:0] status,
                          logic [pqfb_pkg::CNT_W-1:0] waiting);
            dequeue_result_t r;
            n_seen++;
            if (due_results.size() == 0)
                report_mismatch($sformatf("result %0d unexpected: pid %0h status %0d count %0d",
                                          n_seen, pid, status, waiting));
            else
            begin
                r = due_results.pop_front();
                if (pid !== r.pid)
                    report_mismatch($sformatf("result %0d pid_out %0h, want %0h",
                                              n_seen, pid, r.pid));
                if (status !== r.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              n_seen, status, r.status));
                if (waiting !== r.waiting)
                    report_mismatch($sformatf("result %0d queue_len %0d, want %0d",
                                              n_seen, waiting, r.waiting));
            end
        endtask

        task flag_leftovers();
            if (due_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pqfb_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = pqfb_pkg::MODE_ENQ;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pqfb_pkg::M_DATA_W-1:0] m_tdata;
    logic [pqfb_pkg::STAT_W-1:0]   m_tuser;

    queue_bank_shadow    bank;
    bit                  idle_on = 1'b1;
    int                  quiet_cycles = 0;

    per_queue_fifo_bank_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            bank.check_result(m_tdata[pqfb_pkg::PID_W-1:0], m_tuser,
                              m_tdata[pqfb_pkg::PID_W+pqfb_pkg::CNT_W-1:pqfb_pkg::PID_W]);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    task send_op(input logic mode, input logic [pqfb_pkg::QID_W-1:0] qid,
                 input logic [pqfb_pkg::PID_W-1:0] pid);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pid, qid};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bank.note_op(mode, qid, pid);
    endtask

    task wait_results_drained();
        s_tvalid <= 1'b0;
        while (bank.due_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("FAIL per_queue_fifo_bank_unit");
        $finish;
    end

    initial
    begin
        logic [pqfb_pkg::QID_W-1:0] qid;
        logic [pqfb_pkg::QID_W-1:0] deep_q;
        logic                       mode;
        int unsigned                hot [8];

        bank = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty dequeues, extreme ids and alternating bit patterns
        send_op(pqfb_pkg::MODE_DEQ, 10'h000, 22'h3FFFFF);
        send_op(pqfb_pkg::MODE_DEQ, 10'h3FF, 22'h000000);
        send_op(pqfb_pkg::MODE_ENQ, 10'h000, 22'h000000);
        send_op(pqfb_pkg::MODE_ENQ, 10'h000, 22'h3FFFFF);
        send_op(pqfb_pkg::MODE_ENQ, 10'h3FF, 22'h3FFFFF);
        send_op(pqfb_pkg::MODE_ENQ, 10'h3FF, 22'h000000);
        send_op(pqfb_pkg::MODE_ENQ, 10'h155, 22'h2AAAAA);
        send_op(pqfb_pkg::MODE_ENQ, 10'h2AA, 22'h155555);
        send_op(pqfb_pkg::MODE_DEQ, 10'h000, 22'h155555);
        send_op(pqfb_pkg::MODE_DEQ, 10'h000, 22'h2AAAAA);
        send_op(pqfb_pkg::MODE_DEQ, 10'h000, 22'h000000);
        send_op(pqfb_pkg::MODE_DEQ, 10'h3FF, 22'h000000);
        send_op(pqfb_pkg::MODE_ENQ, 10'h3FF, 22'h0F0F0F);
        send_op(pqfb_pkg::MODE_DEQ, 10'h3FF, 22'h000000);
        send_op(pqfb_pkg::MODE_DEQ, 10'h3FF, 22'h000000);
        send_op(pqfb_pkg::MODE_DEQ, 10'h3FF, 22'h000000);
        send_op(pqfb_pkg::MODE_DEQ, 10'h155, 22'h000000);
        send_op(pqfb_pkg::MODE_DEQ, 10'h2AA, 22'h000000);
        wait_results_drained();

        // build one deep queue, touch other queues, then drain it
        deep_q = pqfb_pkg::QID_W'($urandom_range(pqfb_pkg::NUM_QUEUES - 1));
        repeat (150) send_op(pqfb_pkg::MODE_ENQ, deep_q, pqfb_pkg::PID_W'($urandom));
        repeat (4) send_op(pqfb_pkg::MODE_ENQ,
                           pqfb_pkg::QID_W'($urandom_range(pqfb_pkg::NUM_QUEUES - 1)),
                           pqfb_pkg::PID_W'($urandom));
        send_op(pqfb_pkg::MODE_DEQ, deep_q ^ 10'h001, pqfb_pkg::PID_W'($urandom));
        while (bank.q_len[deep_q] != 0)
            send_op(pqfb_pkg::MODE_DEQ, deep_q, pqfb_pkg::PID_W'($urandom));
        send_op(pqfb_pkg::MODE_DEQ, deep_q, pqfb_pkg::PID_W'($urandom));
        wait_results_drained();

        for (int i = 0; i < 8; i++)
            hot[i] = $urandom_range(pqfb_pkg::NUM_QUEUES - 1);
        for (int k = 0; k < 325; k++)
        begin
            idle_on = !(k >= 100 && k < 220);
            if ($urandom_range(99) < 70)
                qid = pqfb_pkg::QID_W'(hot[$urandom_range(7)]);
            else
                qid = pqfb_pkg::QID_W'($urandom_range(pqfb_pkg::NUM_QUEUES - 1));
            mode = ($urandom_range(99) < 55) ? pqfb_pkg::MODE_ENQ : pqfb_pkg::MODE_DEQ;
            send_op(mode, qid, pqfb_pkg::PID_W'($urandom));
        end
        idle_on = 1'b1;

        wait_results_drained();
        repeat (10) @(posedge clk);
        bank.flag_leftovers();
        if (bank.errors == 0)
            $display("PASS per_queue_fifo_bank_unit");
        else
            $display("FAIL per_queue_fifo_bank_unit");
        $finish;
    end
endmodule
